// ===== rtl/pta_pkg.sv =====
`default_nettype none
package pta_pkg;

   // field widths of the request, response and csr transactions
   localparam int MODE_W  = 3;
   localparam int START_W = 14;
   localparam int COUNT_W = 15;
   localparam int VALUE_W = 8;
   localparam int INDEX_W = 15;
   localparam int TOTAL_W = 15;

   // request modes
   localparam logic [MODE_W-1:0] MODE_MARK    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FIND    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CHECK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_COUNT   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_REFRESH = 3'd5;

   // reset values
   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 15'd16384;
   localparam logic [INDEX_W-1:0] HINT_RESET  = 15'd16384;

   // type value written by allocate
   localparam logic [VALUE_W-1:0] ALLOC_VALUE = 8'd1;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic setup;
      logic scan;
      logic clear;
      logic rsp_load;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clear_last;
      logic scan_finished;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/pta_req_if.sv =====
`default_nettype none
interface pta_req_if;
   logic                        valid;
   logic                        ready;
   logic [pta_pkg::MODE_W-1:0]  mode;
   logic [pta_pkg::START_W-1:0] start_page;
   logic [pta_pkg::COUNT_W-1:0] page_count;
   logic [pta_pkg::VALUE_W-1:0] mark_value;

   modport source (output valid, mode, start_page, page_count, mark_value, input ready);
   modport sink   (input valid, mode, start_page, page_count, mark_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/pta_rsp_if.sv =====
`default_nettype none
interface pta_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        ok;
   logic [pta_pkg::INDEX_W-1:0] page_index;
   logic [pta_pkg::COUNT_W-1:0] free_count;

   modport source (output valid, ok, page_index, free_count, input ready);
   modport sink   (input valid, ok, page_index, free_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/pta_csr_if.sv =====
`default_nettype none
interface pta_csr_if;
   logic                        valid;
   logic                        ready;
   logic [pta_pkg::TOTAL_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pta_ram.sv =====
`default_nettype none
module pta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule
`default_nettype wire

// ===== rtl/pta_datapath.sv =====
`default_nettype none
module pta_datapath #(
   parameter int MAX_PAGES = 16384
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire pta_pkg::cmd_type            cmd,
   output pta_pkg::status_type              status,
   input  wire logic                        csr_we,
   input  wire logic [pta_pkg::TOTAL_W-1:0] csr_data,
   input  wire logic [pta_pkg::MODE_W-1:0]  req_mode,
   input  wire logic [pta_pkg::START_W-1:0] req_start,
   input  wire logic [pta_pkg::COUNT_W-1:0] req_count,
   input  wire logic [pta_pkg::VALUE_W-1:0] req_value,
   output logic                             rsp_ok,
   output logic      [pta_pkg::INDEX_W-1:0] rsp_index,
   output logic      [pta_pkg::COUNT_W-1:0] rsp_free
);

   localparam int AW = $clog2(MAX_PAGES);
   localparam int CW = AW + 1;
   // one bit above the wider of the page range and the count field, so start + count fits
   localparam int SW = ((CW > 15) ? CW : 15) + 1;
   localparam logic [SW-1:0] MAX_SW  = SW'(MAX_PAGES);
   localparam logic [SW-1:0] LAST_SW = SW'(MAX_PAGES - 1);

   // captured request
   logic [pta_pkg::MODE_W-1:0]  mode_ff;
   logic [pta_pkg::START_W-1:0] start_ff;
   logic [pta_pkg::COUNT_W-1:0] count_ff;
   logic [pta_pkg::VALUE_W-1:0] value_ff;

   // scan state
   logic [SW-1:0]               addr_ff, addr_in;
   logic [SW-1:0]               remain_ff, remain_in;
   logic                        down_ff, down_in;
   logic                        write_ff, write_in;
   logic [pta_pkg::VALUE_W-1:0] wval_ff, wval_in;
   logic                        pend_ff;
   logic [SW-1:0]               pend_addr_ff;
   logic                        done_ff, done_in;
   logic                        ok_ff, ok_in;
   logic [SW-1:0]               idx_ff, idx_in;
   logic [SW-1:0]               run_ff, run_in;
   logic [SW-1:0]               cnt_ff, cnt_in;
   logic [pta_pkg::TOTAL_W-1:0] total_ff;
   logic [pta_pkg::INDEX_W-1:0] hint_ff, hint_in;

   logic                        ram_we;
   logic [pta_pkg::VALUE_W-1:0] ram_wdata, ram_rdata;
   logic                        issue;

   logic [SW-1:0] start_w, count_w, sum_w, lim_w, hint_w, hclamp_w, end_w, total_w, run_next;

   always_comb begin
      start_w  = SW'(start_ff);
      count_w  = SW'(count_ff);
      total_w  = SW'(total_ff);
      hint_w   = SW'(hint_ff);
      sum_w    = start_w + count_w;
      lim_w    = (total_w < MAX_SW) ? total_w : MAX_SW;
      hclamp_w = (hint_w > lim_w) ? lim_w : hint_w;
      end_w    = (sum_w < MAX_SW) ? sum_w : MAX_SW;
      run_next = run_ff + SW'(1);
   end

   assign issue = cmd.scan && (remain_ff != '0) && !done_ff;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         start_ff <= req_start;
         count_ff <= req_count;
         value_ff <= req_value;
      end
   end

   // clearing walk, setup, scan issue and evaluation of returned entries
   always_comb begin
      addr_in   = addr_ff;
      remain_in = remain_ff;
      down_in   = down_ff;
      write_in  = write_ff;
      wval_in   = wval_ff;
      done_in   = done_ff;
      ok_in     = ok_ff;
      idx_in    = idx_ff;
      run_in    = run_ff;
      cnt_in    = cnt_ff;
      hint_in   = hint_ff;
      if (cmd.clear) begin
         addr_in = addr_ff + SW'(1);
      end else if (cmd.setup) begin
         done_in   = 1'b0;
         run_in    = '0;
         cnt_in    = '0;
         idx_in    = '0;
         ok_in     = 1'b1;
         write_in  = 1'b0;
         down_in   = 1'b0;
         wval_in   = value_ff;
         addr_in   = '0;
         remain_in = '0;
         unique case (mode_ff) inside
            pta_pkg::MODE_MARK, pta_pkg::MODE_ALLOC: begin
               write_in  = 1'b1;
               addr_in   = start_w;
               remain_in = (start_w >= MAX_SW) ? '0 : end_w - start_w;
               if (mode_ff == pta_pkg::MODE_ALLOC) begin
                  wval_in = pta_pkg::ALLOC_VALUE;
               end
            end
            pta_pkg::MODE_FIND: begin
               ok_in     = 1'b0;
               hint_in   = hclamp_w[pta_pkg::INDEX_W-1:0];
               down_in   = 1'b1;
               addr_in   = hclamp_w - SW'(1);
               remain_in = hclamp_w;
            end
            pta_pkg::MODE_CHECK: begin
               if (sum_w > lim_w) begin
                  ok_in = 1'b0;
               end else begin
                  addr_in   = start_w;
                  remain_in = count_w;
               end
            end
            pta_pkg::MODE_COUNT: begin
               remain_in = lim_w;
            end
            pta_pkg::MODE_REFRESH: begin
               ok_in     = 1'b0;
               down_in   = 1'b1;
               addr_in   = lim_w - SW'(1);
               remain_in = lim_w;
            end
            default: begin
            end
         endcase
      end else if (cmd.scan) begin
         if (issue) begin
            addr_in   = down_ff ? addr_ff - SW'(1) : addr_ff + SW'(1);
            remain_in = remain_ff - SW'(1);
         end
         if (pend_ff && !done_ff) begin
            unique case (mode_ff)
               pta_pkg::MODE_FIND: begin
                  if (ram_rdata != '0) begin
                     run_in = '0;
                  end else begin
                     run_in = run_next;
                     if (run_next >= count_w) begin
                        done_in = 1'b1;
                        ok_in   = 1'b1;
                        idx_in  = pend_addr_ff;
                     end
                  end
               end
               pta_pkg::MODE_CHECK: begin
                  if (ram_rdata != '0) begin
                     done_in = 1'b1;
                     ok_in   = 1'b0;
                  end
               end
               pta_pkg::MODE_COUNT: begin
                  if (ram_rdata == '0) begin
                     cnt_in = cnt_ff + SW'(1);
                  end
               end
               pta_pkg::MODE_REFRESH: begin
                  if (ram_rdata == '0) begin
                     done_in = 1'b1;
                     ok_in   = 1'b1;
                     hint_in = pta_pkg::INDEX_W'(pend_addr_ff + SW'(1));
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= '0;
         remain_ff <= '0;
         pend_ff   <= 1'b0;
         done_ff   <= 1'b0;
         total_ff  <= pta_pkg::TOTAL_RESET;
         hint_ff   <= pta_pkg::HINT_RESET;
      end else begin
         addr_ff   <= addr_in;
         remain_ff <= remain_in;
         pend_ff   <= issue && !write_ff;
         done_ff   <= done_in;
         hint_ff   <= hint_in;
         if (csr_we) begin
            total_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      down_ff      <= down_in;
      write_ff     <= write_in;
      wval_ff      <= wval_in;
      ok_ff        <= ok_in;
      idx_ff       <= idx_in;
      run_ff       <= run_in;
      cnt_ff       <= cnt_in;
      pend_addr_ff <= addr_ff;
   end

   // table port
   assign ram_we    = cmd.clear || (issue && write_ff);
   assign ram_wdata = cmd.clear ? '0 : wval_ff;

   pta_ram #(
      .WIDTH (pta_pkg::VALUE_W),
      .DEPTH (MAX_PAGES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (addr_ff[AW-1:0]),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // status
   assign status.clear_last    = (addr_ff == LAST_SW);
   assign status.scan_finished = done_ff || ((remain_ff == '0) && !pend_ff);

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ok    <= ok_ff;
         rsp_index <= (mode_ff == pta_pkg::MODE_REFRESH) ? hint_ff
                                                          : idx_ff[pta_pkg::INDEX_W-1:0];
         rsp_free  <= cnt_ff[pta_pkg::COUNT_W-1:0];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/pta_ctrl.sv =====
`default_nettype none
module pta_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire pta_pkg::status_type status,
   output pta_pkg::cmd_type         cmd,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_finished) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // no request taken during the clearing pass
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request ready during clear");

   // a loaded response is presented next cycle
   a_rsp_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("response not presented after load");

   // a finished scan moves to the response stage
   a_scan_to_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && status.scan_finished) |=> (state_ff == ST_DONE))
      else $error("scan finish lost");

   // a response is never loaded over one not yet taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten");

endmodule
`default_nettype wire

// ===== rtl/page_table_allocator_top.sv =====
// channel   dir  handshake      payload
// req_bus   in   valid/ready    mode, start_page, page_count, mark_value
// rsp_bus   out  valid/ready    ok, page_index, free_count
// csr_bus   in   valid/ready    data (total_pages), always ready
//
// one request at a time; a request walks the table entries it covers one by one
// through the single table port (up to MAX_PAGES entries), a check or find stops
// at its first decisive entry
// after reset a clearing pass zeroes every table entry, req_ready low
// the response register lets the next request start while a response waits
`default_nettype none
module page_table_allocator_top #(
   parameter int MAX_PAGES = 16384
) (
   input wire logic clock,
   input wire logic reset,
   pta_req_if.sink  req_bus,
   pta_rsp_if.source rsp_bus,
   pta_csr_if.sink  csr_bus
);

   pta_pkg::cmd_type    cmd;
   pta_pkg::status_type status;

   assign csr_bus.ready = 1'b1;

   pta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready)
   );

   pta_datapath #(
      .MAX_PAGES (MAX_PAGES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_bus.valid),
      .csr_data  (csr_bus.data),
      .req_mode  (req_bus.mode),
      .req_start (req_bus.start_page),
      .req_count (req_bus.page_count),
      .req_value (req_bus.mark_value),
      .rsp_ok    (rsp_bus.ok),
      .rsp_index (rsp_bus.page_index),
      .rsp_free  (rsp_bus.free_count)
   );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
module testbench;

   localparam int TABLE_PAGES = 16384;
   localparam int LONG_HOLD   = 400;
   localparam int QUIET_ITEMS = 15;

   // modes with no function, answered with the default response
   localparam logic [pta_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
   localparam logic [pta_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;

   typedef struct {
      logic [pta_pkg::MODE_W-1:0]  mode;
      logic [pta_pkg::START_W-1:0] start_page;
      logic [pta_pkg::COUNT_W-1:0] page_count;
      logic [pta_pkg::VALUE_W-1:0] mark_value;
   } page_request_type;

   typedef struct {
      logic                        ok;
      logic [pta_pkg::INDEX_W-1:0] page_index;
      logic [pta_pkg::COUNT_W-1:0] free_count;
   } page_response_type;

   // one row of the directed table: a csr write or a request
   typedef struct {
      bit                          is_csr;
      logic [pta_pkg::TOTAL_W-1:0] csr_data;
      page_request_type            req;
      bit                          typed;
      page_response_type           rsp;
   } directed_row_type;

   logic clock;
   logic reset;

   pta_req_if req_bus();
   pta_rsp_if rsp_bus();
   pta_csr_if csr_bus();

   page_table_allocator_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   // shadow copy of the page table and its registers
   logic [pta_pkg::VALUE_W-1:0] page_type [TABLE_PAGES];
   int unsigned                 free_hint_q;
   int unsigned                 total_pages_q;

   page_response_type pending_rsp[$];
   bit                failed;
   bit                quiet;
   bit                hold_rsp;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // timeout
   initial begin
      #40_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // predicted response of one request, updating the shadow state
   function automatic page_response_type predict_page_op(input page_request_type r);
      page_response_type res;
      int unsigned       lim;
      int unsigned       run;
      int unsigned       p;
      int unsigned       last;
      res.ok = 1'b1;
      res.page_index = '0;
      res.free_count = '0;
      lim = (total_pages_q < TABLE_PAGES) ? total_pages_q : TABLE_PAGES;
      last = int'(r.start_page) + int'(r.page_count);
      case (r.mode) inside
         pta_pkg::MODE_MARK, pta_pkg::MODE_ALLOC: begin
            for (p = r.start_page; p < last && p < TABLE_PAGES; p++)
               page_type[p] = (r.mode == pta_pkg::MODE_MARK) ? r.mark_value
                                                             : pta_pkg::ALLOC_VALUE;
         end
         pta_pkg::MODE_FIND: begin
            if (free_hint_q > lim) free_hint_q = lim;
            res.ok = 1'b0;
            run = 0;
            for (p = free_hint_q; p > 0; p--) begin
               if (page_type[p-1] != 0) begin
                  run = 0;
               end else begin
                  run++;
                  if (run >= r.page_count) begin
                     res.ok = 1'b1;
                     res.page_index = pta_pkg::INDEX_W'(p - 1);
                     break;
                  end
               end
            end
         end
         pta_pkg::MODE_CHECK: begin
            if (last > lim) begin
               res.ok = 1'b0;
            end else begin
               for (p = r.start_page; p < last; p++)
                  if (page_type[p] != 0) begin
                     res.ok = 1'b0;
                     break;
                  end
            end
         end
         pta_pkg::MODE_COUNT: begin
            for (p = 0; p < lim; p++)
               if (page_type[p] == 0) res.free_count++;
         end
         pta_pkg::MODE_REFRESH: begin
            res.ok = 1'b0;
            for (p = lim; p > 0; p--)
               if (page_type[p-1] == 0) begin
                  free_hint_q = p;
                  res.ok = 1'b1;
                  break;
               end
            res.page_index = pta_pkg::INDEX_W'(free_hint_q);
         end
         default: ;
      endcase
      return res;
   endfunction

   // offer one request, wait for its transaction and record the expectation
   task automatic send_request(input page_request_type r, input bit typed,
                               input page_response_type typed_rsp);
      page_response_type res;
      int                gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= r.mode;
      req_bus.start_page <= r.start_page;
      req_bus.page_count <= r.page_count;
      req_bus.mark_value <= r.mark_value;
      do @(posedge clock); while (!req_bus.ready);
      res = predict_page_op(r);
      pending_rsp.push_back(typed ? typed_rsp : res);
   endtask

   // csr write only once the block has drained
   task automatic write_total_pages(input logic [pta_pkg::TOTAL_W-1:0] pages);
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= pages;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      total_pages_q = pages;
   endtask

   // random request, mostly inside the active limit
   function automatic page_request_type random_request(input int unsigned lim);
      page_request_type r;
      int unsigned      pick;
      int unsigned      span;
      span = (lim < 16) ? 16 : lim + 8;
      pick = $urandom_range(0, 99);
      r.mark_value = ($urandom_range(0, 2) == 0) ? 8'd0 : pta_pkg::VALUE_W'($urandom);
      r.start_page = pta_pkg::START_W'($urandom_range(0, span - 1));
      r.page_count = pta_pkg::COUNT_W'($urandom_range(0, 24));
      if (pick < 20)      r.mode = pta_pkg::MODE_MARK;
      else if (pick < 35) r.mode = pta_pkg::MODE_ALLOC;
      else if (pick < 58) r.mode = pta_pkg::MODE_FIND;
      else if (pick < 78) r.mode = pta_pkg::MODE_CHECK;
      else if (pick < 86) r.mode = pta_pkg::MODE_COUNT;
      else if (pick < 94) r.mode = pta_pkg::MODE_REFRESH;
      else                r.mode = (pick < 97) ? MODE_SPARE6 : MODE_SPARE7;
      // rare wide ranges so that every field bit toggles
      if ($urandom_range(0, 19) == 0) begin
         r.start_page = pta_pkg::START_W'($urandom);
         r.page_count = pta_pkg::COUNT_W'($urandom_range(0, TABLE_PAGES));
      end
      return r;
   endfunction

   // response side: random stalls, one long hold-off, and checking
   initial begin
      page_response_type want;
      int                gap;
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_rsp.size() == 0) begin
               $error("response transaction with none expected");
               failed = 1'b1;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_bus.ok !== want.ok) begin
                  $error("ok: expected %0d, actual %0d", want.ok, rsp_bus.ok);
                  failed = 1'b1;
               end
               if (rsp_bus.page_index !== want.page_index) begin
                  $error("page_index: expected %0d, actual %0d",
                         want.page_index, rsp_bus.page_index);
                  failed = 1'b1;
               end
               if (rsp_bus.free_count !== want.free_count) begin
                  $error("free_count: expected %0d, actual %0d",
                         want.free_count, rsp_bus.free_count);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      directed_row_type  rows[$];
      page_response_type none;
      int unsigned       phase_limit[7];
      int unsigned       phase_items[7];
      int                total_random;
      int                sent;
      int                wait_cycles;

      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.mode = pta_pkg::MODE_MARK;
      req_bus.start_page = '0;
      req_bus.page_count = '0;
      req_bus.mark_value = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      failed = 1'b0;
      quiet = 1'b0;
      hold_rsp = 1'b0;
      none = '{ok: 1'b1, page_index: '0, free_count: '0};
      foreach (page_type[i]) page_type[i] = '0;
      free_hint_q = pta_pkg::HINT_RESET;
      total_pages_q = pta_pkg::TOTAL_RESET;

      // directed table: csr flag, data, request, typed flag, response
      rows = '{
         '{0, 0, '{pta_pkg::MODE_COUNT,   0,     0,     0},   1, '{1, 0,     16384}},
         '{0, 0, '{pta_pkg::MODE_REFRESH, 0,     0,     0},   1, '{1, 16384, 0}},
         '{0, 0, '{pta_pkg::MODE_FIND,    0,     0,     0},   1, '{1, 16383, 0}},
         '{0, 0, '{pta_pkg::MODE_MARK,    16383, 16384, 255}, 1, '{1, 0,     0}},
         '{0, 0, '{pta_pkg::MODE_FIND,    0,     1,     0},   1, '{1, 16382, 0}},
         '{0, 0, '{pta_pkg::MODE_CHECK,   16383, 1,     0},   1, '{0, 0,     0}},
         '{0, 0, '{pta_pkg::MODE_CHECK,   16383, 2,     0},   1, '{0, 0,     0}},
         '{0, 0, '{pta_pkg::MODE_CHECK,   0,     0,     0},   1, '{1, 0,     0}},
         '{0, 0, '{pta_pkg::MODE_ALLOC,   0,     16,    0},   1, '{1, 0,     0}},
         '{0, 0, '{pta_pkg::MODE_MARK,    16,    4,     128}, 0, '{1, 0,     0}},
         '{0, 0, '{pta_pkg::MODE_CHECK,   0,     32,    0},   1, '{0, 0,     0}},
         '{0, 0, '{pta_pkg::MODE_COUNT,   0,     0,     0},   1, '{1, 0,     16363}},
         '{0, 0, '{MODE_SPARE6,           9,     9,     9},   1, '{1, 0,     0}},
         '{0, 0, '{MODE_SPARE7,           16383, 16384, 255}, 1, '{1, 0,     0}},
         '{0, 0, '{pta_pkg::MODE_MARK,    16383, 1,     0},   0, '{1, 0,     0}},
         '{0, 0, '{pta_pkg::MODE_FIND,    0,     16384, 0},   1, '{0, 0,     0}},
         '{0, 0, '{pta_pkg::MODE_REFRESH, 0,     0,     0},   1, '{1, 16384, 0}},
         '{0, 0, '{pta_pkg::MODE_FIND,    0,     5,     0},   0, '{1, 0,     0}},
         // empty table limit: no free page, hint kept
         '{1, 0, '{pta_pkg::MODE_MARK,    0,     0,     0},   0, '{1, 0,     0}},
         '{0, 0, '{pta_pkg::MODE_REFRESH, 0,     0,     0},   1, '{0, 16384, 0}},
         '{0, 0, '{pta_pkg::MODE_FIND,    0,     1,     0},   1, '{0, 0,     0}},
         '{0, 0, '{pta_pkg::MODE_COUNT,   0,     0,     0},   1, '{1, 0,     0}},
         '{0, 0, '{pta_pkg::MODE_CHECK,   0,     0,     0},   1, '{1, 0,     0}},
         '{0, 0, '{pta_pkg::MODE_REFRESH, 0,     0,     0},   1, '{0, 0,     0}}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].is_csr) write_total_pages(rows[i].csr_data);
         else send_request(rows[i].req, rows[i].typed, rows[i].rsp);
      end

      // random phases, most with a small limit to keep scans short
      phase_limit = '{64, 1, 200, 16384, 32, 16383, 48};
      phase_items = '{20, 8, 20, 5, 20, 4, 25};
      total_random = 0;
      foreach (phase_items[i]) total_random += phase_items[i];
      sent = 0;
      foreach (phase_limit[ph]) begin
         write_total_pages(pta_pkg::TOTAL_W'(phase_limit[ph]));
         for (int k = 0; k < phase_items[ph]; k++) begin
            if (sent == 30) hold_rsp = 1'b1;
            if (sent >= total_random - QUIET_ITEMS) quiet = 1'b1;
            send_request(random_request(phase_limit[ph]), 1'b0, none);
            sent++;
         end
      end
      req_bus.valid <= 1'b0;

      // drain
      wait_cycles = 0;
      while (pending_rsp.size() != 0 && wait_cycles < 200_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (50) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d responses never arrived", pending_rsp.size());
         failed = 1'b1;
      end
      if (!failed) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire
